// File: sv/sam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sam_pkg
// Shared constants, command type and helper functions for the ARX mixing
// array: word count, address width, operation codes and round offsets.
// ----------------------------------------------------------------------------
package sam_pkg;

  localparam int WORDS   = 64;
  localparam int AW      = $clog2(WORDS);
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 6;
  localparam int FUNC_W  = 2;
  localparam int SUM_W   = 8;
  localparam int ROT_W   = 5;

  // operation codes carried by func
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MIX   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

  localparam logic [WORD_W-1:0] GOLDEN_MUL = 32'h9E3779B1;

  // fixed address offsets used by one round
  localparam logic [SUM_W-1:0] OFF_R_ADD   = 8'd82;
  localparam logic [SUM_W-1:0] OFF_I_XOR   = 8'd19;
  localparam logic [SUM_W-1:0] OFF_I_ROT   = 8'd83;
  localparam logic [SUM_W-1:0] OFF_R_XOR   = 8'd52;
  localparam logic [SUM_W-1:0] OFF_I_TERM  = 8'd24;
  localparam logic [SUM_W-1:0] OFF_R_AMT   = 8'd31;
  localparam logic [SUM_W-1:0] OFF_IR_ADD  = 8'd7;
  localparam int               DIFF_SHIFT  = 1;
  localparam int               FOLD_SHIFT  = 16;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] value;
  } cmd_t;

  // reduce an offset sum modulo the word count
  function automatic logic [AW-1:0] addr_of(input logic [SUM_W-1:0] sum);
    logic [SUM_W+AW-1:0] wide;
    wide = {{AW{1'b0}}, sum};
    return wide[AW-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                             input logic [ROT_W-1:0]  amt);
    logic [2*WORD_W-1:0] dbl;
    dbl = {v, v} >> amt;
    return dbl[WORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/sam_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sam_front
// Input side: takes items, drops unused operation codes and holds accepted
// commands in a short queue until the back end pops them.
// ----------------------------------------------------------------------------
module sam_front
  import sam_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [IDX_W-1:0]  index_i,
  input  wire logic [WORD_W-1:0] write_value_i,
  output logic                   cmd_valid_o,
  output cmd_t                   cmd_o,
  input  wire logic              cmd_pop_i
);

  cmd_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] count_q, count_d;
  logic               push;
  logic               pop;

  assign in_stall_o  = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  // unused code is consumed here and never reaches the back end
  assign push = in_valid_i && !in_stall_o && (func_i != FUNC_NONE);
  assign pop  = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{func: func_i, index: index_i, value: write_value_i};
    end
  end

endmodule
`default_nettype wire

// File: sv/sam_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sam_back
// Execution side: holds the word memory and sequences writes, reads and the
// four mixing rounds plus diffusion through one read and one write port.
// ----------------------------------------------------------------------------
module sam_back
  import sam_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire cmd_t              cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [WORD_W-1:0]      read_value_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;
  localparam logic [1:0] ST_DIFF  = 2'd3;

  // round steps: ISSUE to MIXT each issue one read whose data is used on the next step
  localparam logic [3:0] RS_ISSUE  = 4'd0;
  localparam logic [3:0] RS_LOAD   = 4'd1;
  localparam logic [3:0] RS_ADD    = 4'd2;
  localparam logic [3:0] RS_XOR    = 4'd3;
  localparam logic [3:0] RS_MULROT = 4'd4;
  localparam logic [3:0] RS_TERM   = 4'd5;
  localparam logic [3:0] RS_AMT    = 4'd6;
  localparam logic [3:0] RS_MIXT   = 4'd7;
  localparam logic [3:0] RS_ADD2   = 4'd8;
  localparam logic [3:0] RS_MULG   = 4'd9;
  localparam logic [3:0] RS_STORE  = 4'd10;

  localparam logic [3:0] DS_ISSUE  = 4'd0;
  localparam logic [3:0] DS_LOAD   = 4'd1;
  localparam logic [3:0] DS_STORE  = 4'd2;

  localparam logic [1:0] LAST_ROUND = 2'd3;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  valid_q;

  logic [1:0]        state_q, state_d;
  logic [3:0]        step_q, step_d;
  logic [1:0]        rnd_q, rnd_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] t1_q, t1_d;
  logic [ROT_W-1:0]  amt_q, amt_d;
  logic              hit_q, hit_d;
  logic [WORD_W-1:0] rdata_q;
  logic              rvld_q;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_data_q, out_data_d;

  logic              rd_en;
  logic [SUM_W-1:0]  rd_sum;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] fold;
  logic [SUM_W-1:0]  r_ext;
  logic [SUM_W-1:0]  i_ext;
  logic [AW-1:0]     dst;

  assign r_ext   = {{(SUM_W-2){1'b0}}, rnd_q};
  assign i_ext   = {{(SUM_W-IDX_W){1'b0}}, idx_q};
  assign dst     = addr_of(r_ext);
  assign rd_addr = addr_of(rd_sum);

  // word under work in acc overrides a stale memory copy
  assign x    = hit_q ? acc_q : (rvld_q ? rdata_q : '0);
  assign prod = acc_q * rotr(acc_q, x[ROT_W-1:0]);
  assign fold = acc_q ^ (acc_q >> FOLD_SHIFT);

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_data_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q + 1'b1;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    t1_d        = t1_q;
    amt_d       = amt_q;
    rd_en       = 1'b0;
    rd_sum      = '0;
    wr_en       = 1'b0;
    wr_addr     = dst;
    wr_data     = fold;
    cmd_pop_o   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    hit_d       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (cmd_valid_i) begin
          case (cmd_i.func)
            FUNC_WRITE: begin
              cmd_pop_o = 1'b1;
              wr_en     = 1'b1;
              wr_addr   = addr_of({{(SUM_W-IDX_W){1'b0}}, cmd_i.index});
              wr_data   = cmd_i.value;
            end
            FUNC_READ: begin
              // result register must be free before a read starts
              if (!out_valid_q) begin
                cmd_pop_o = 1'b1;
                rd_en     = 1'b1;
                rd_sum    = {{(SUM_W-IDX_W){1'b0}}, cmd_i.index};
                state_d   = ST_READ;
              end
            end
            FUNC_MIX: begin
              cmd_pop_o = 1'b1;
              idx_d     = cmd_i.index;
              rnd_d     = '0;
              state_d   = ST_ROUND;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        out_valid_d = 1'b1;
        out_data_d  = x;
        state_d     = ST_IDLE;
      end

      ST_ROUND: begin
        case (step_q)
          RS_ISSUE: begin
            rd_en  = 1'b1;
            rd_sum = r_ext;
          end
          RS_LOAD: begin
            acc_d  = x;
            rd_en  = 1'b1;
            rd_sum = r_ext + OFF_R_ADD;
          end
          RS_ADD: begin
            acc_d  = acc_q + x;
            rd_en  = 1'b1;
            rd_sum = i_ext + OFF_I_XOR;
          end
          RS_XOR: begin
            acc_d  = acc_q ^ x;
            rd_en  = 1'b1;
            rd_sum = i_ext + OFF_I_ROT;
          end
          RS_MULROT: begin
            acc_d  = prod;
            rd_en  = 1'b1;
            rd_sum = r_ext + OFF_R_XOR;
          end
          RS_TERM: begin
            t1_d   = x;
            rd_en  = 1'b1;
            rd_sum = r_ext + OFF_R_AMT;
          end
          RS_AMT: begin
            amt_d  = x[ROT_W-1:0];
            rd_en  = 1'b1;
            rd_sum = i_ext + OFF_I_TERM;
          end
          RS_MIXT: begin
            acc_d  = acc_q ^ t1_q ^ rotr(x, amt_q);
            rd_en  = 1'b1;
            rd_sum = i_ext + r_ext + OFF_IR_ADD;
          end
          RS_ADD2: begin
            acc_d = acc_q + x;
          end
          RS_MULG: begin
            acc_d = acc_q * GOLDEN_MUL;
          end
          RS_STORE: begin
            wr_en   = 1'b1;
            wr_addr = dst;
            wr_data = fold;
            step_d  = '0;
            rnd_d   = rnd_q + 1'b1;
            if (rnd_q == LAST_ROUND) begin
              state_d = ST_DIFF;
            end
          end
          default: begin
            step_d = '0;
          end
        endcase
        hit_d = rd_en && (rd_addr == dst) && (step_q != RS_ISSUE);
      end

      ST_DIFF: begin
        case (step_q)
          DS_ISSUE: begin
            rd_en  = 1'b1;
            rd_sum = r_ext;
          end
          DS_LOAD: begin
            acc_d  = x;
            rd_en  = 1'b1;
            rd_sum = r_ext + 1'b1;
          end
          DS_STORE: begin
            wr_en   = 1'b1;
            wr_addr = dst;
            wr_data = acc_q ^ (x >> DIFF_SHIFT);
            step_d  = '0;
            rnd_d   = rnd_q + 1'b1;
            if (rnd_q == LAST_ROUND) begin
              state_d = ST_IDLE;
            end
          end
          default: begin
            step_d = '0;
          end
        endcase
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      rnd_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      rvld_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      rnd_q       <= rnd_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= valid_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    acc_q      <= acc_d;
    t1_q       <= t1_d;
    amt_q      <= amt_d;
    out_data_q <= out_data_d;
  end

  // word memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sv/state_array_arx_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// state_array_arx_mixer
// Array of 32-bit mixing words with write, read and add-rotate-xor-multiply
// mix operations.
// ----------------------------------------------------------------------------
// A two-entry command queue takes items while the engine works, so the input
// stalls only when the queue is full. The engine owns a word memory with one
// read and one write port, and that single read port sets the pace of a mix:
// four rounds, then four diffusion steps. A read result sits in an output
// register until taken; a further read waits for it, writes and mixes do not.
// All words read as zero after reset. Func code 3 is taken and dropped
// without effect.
// ----------------------------------------------------------------------------
module state_array_arx_mixer
  import sam_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [IDX_W-1:0]  index_i,
  input  wire logic [WORD_W-1:0] write_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [WORD_W-1:0]      read_value_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  sam_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .index_i       (index_i),
    .write_value_i (write_value_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  sam_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o)
  );

endmodule
`default_nettype wire

// File: sim/state_array_arx_mixer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_array_arx_mixer_tb
// Self-checking bench for the ARX mixing array. A directed table of writes,
// reads, mixes and dropped items runs first, then random traffic under three
// idling regimes. Each read result is compared with a behavioural model of
// the word array kept inside the bench, or with the known value from the table.
// ----------------------------------------------------------------------------
module state_array_arx_mixer_tb
  import sam_pkg::*;
;

  localparam int          DIR_ROWS     = 24;
  localparam int          PHASE_ITEMS  = 550;
  localparam int          HOLD_READS   = 8;
  localparam int          TOTAL_RANDOM = 1680;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 120;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [31:0] MIX_MUL      = 32'h9E3779B1;

  // address offsets of one round
  localparam int R_ADD  = 82;
  localparam int I_XOR  = 19;
  localparam int I_ROT  = 83;
  localparam int R_XOR  = 52;
  localparam int I_TERM = 24;
  localparam int R_AMT  = 31;
  localparam int IR_ADD = 7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] value;
    logic              known;
    logic [WORD_W-1:0] known_word;
  } stim_row_t;

  // known is set where the read-back value is obvious by inspection
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{FUNC_READ,  6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
    '{FUNC_MIX,   6'd5,  32'h0000_0000, 1'b0, 32'h0000_0000},
    '{FUNC_READ,  6'd0,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{FUNC_READ,  6'd63, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{FUNC_WRITE, 6'd0,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{FUNC_WRITE, 6'd63, 32'h8000_0001, 1'b0, 32'h0000_0000},
    '{FUNC_NONE,  6'd0,  32'h1234_5678, 1'b0, 32'h0000_0000},
    '{FUNC_NONE,  6'd63, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{FUNC_READ,  6'd0,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{FUNC_READ,  6'd63, 32'hFFFF_FFFF, 1'b1, 32'h8000_0001},
    '{FUNC_WRITE, 6'd18, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000},
    '{FUNC_WRITE, 6'd1,  32'h0000_0020, 1'b0, 32'h0000_0000},
    '{FUNC_WRITE, 6'd19, 32'h0000_001F, 1'b0, 32'h0000_0000},
    '{FUNC_MIX,   6'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
    '{FUNC_READ,  6'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
    '{FUNC_READ,  6'd1,  32'h0000_0000, 1'b0, 32'h0000_0000},
    '{FUNC_MIX,   6'd63, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{FUNC_READ,  6'd2,  32'h0000_0000, 1'b0, 32'h0000_0000},
    '{FUNC_READ,  6'd3,  32'h0000_0000, 1'b0, 32'h0000_0000},
    '{FUNC_MIX,   6'd45, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{FUNC_READ,  6'd4,  32'h0000_0000, 1'b0, 32'h0000_0000},
    '{FUNC_MIX,   6'd57, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{FUNC_READ,  6'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
    '{FUNC_READ,  6'd63, 32'h0000_0000, 1'b0, 32'h0000_0000}
  };

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [FUNC_W-1:0] func_i        = FUNC_WRITE;
  logic [IDX_W-1:0]  index_i       = '0;
  logic [WORD_W-1:0] write_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [WORD_W-1:0] read_value_o;

  logic [WORD_W-1:0] mix_state [WORDS];
  logic [WORD_W-1:0] pending_reads [$];
  logic [WORD_W-1:0] want_word;
  int                mismatches    = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_req      = 0;
  int                hold_ack      = 0;
  int                hold_left     = 0;

  state_array_arx_mixer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .index_i       (index_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [31:0] rot_right(logic [31:0] v, logic [31:0] amt_word);
    int amt;
    amt = int'(amt_word[4:0]);
    if (amt == 0) return v;
    return (v >> amt) | (v << (32 - amt));
  endfunction

  function automatic logic [31:0] word_at(int a);
    return mix_state[a & (WORDS - 1)];
  endfunction

  // each step reads the array as left by the step before it
  task automatic mix_round(int r, int i);
    int          d;
    logic [31:0] t;
    d = r & (WORDS - 1);
    mix_state[d] = mix_state[d] + word_at(r + R_ADD);
    mix_state[d] = mix_state[d] ^ word_at(i + I_XOR);
    mix_state[d] = mix_state[d] * rot_right(mix_state[d], word_at(i + I_ROT));
    t = word_at(r + R_XOR) ^ rot_right(word_at(i + I_TERM), word_at(r + R_AMT));
    mix_state[d] = mix_state[d] ^ t;
    mix_state[d] = mix_state[d] + word_at(i + r + IR_ADD);
    mix_state[d] = mix_state[d] * MIX_MUL;
    mix_state[d] = mix_state[d] ^ (mix_state[d] >> 16);
  endtask

  task automatic run_mix(int i);
    for (int r = 0; r < 4; r++) mix_round(r, i);
    for (int k = 0; k < 4; k++) mix_state[k] = mix_state[k] ^ (word_at(k + 1) >> 1);
  endtask

  task automatic apply_item(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] ix,
                            input logic [WORD_W-1:0] v, output bit has_read,
                            output logic [WORD_W-1:0] read_word);
    has_read  = 1'b0;
    read_word = '0;
    case (f)
      FUNC_WRITE: begin
        mix_state[int'(ix) & (WORDS - 1)] = v;
      end
      FUNC_READ: begin
        has_read  = 1'b1;
        read_word = word_at(int'(ix));
      end
      FUNC_MIX: begin
        run_mix(int'(ix));
      end
      default: begin
      end
    endcase
  endtask

  // -------------------------------------------------------------- driving

  task automatic send_item(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] ix,
                           logic [WORD_W-1:0] v, bit known, logic [WORD_W-1:0] known_word);
    bit          has_read;
    logic [31:0] word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    index_i       <= ix;
    write_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(f, ix, v, has_read, word);
    if (has_read) pending_reads.push_back(known ? known_word : word);
  endtask

  // always waits on the clock before returning, so valid is never dropped and raised in one step
  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_reads.size() != 0);
  endtask

  task automatic random_traffic(int quota);
    int                sent;
    int                pick;
    logic [FUNC_W-1:0] f;
    logic [IDX_W-1:0]  ix;
    logic [WORD_W-1:0] v;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      ix   = IDX_W'($urandom_range(63));
      v    = $urandom;
      case ($urandom_range(15))
        0:       v = '0;
        1:       v = '1;
        2:       v[4:0] = '0;
        default: ;
      endcase
      if (pick < 30) begin
        f = FUNC_WRITE;
      end else if (pick < 65) begin
        f = FUNC_READ;
        // words 0 to 3 are the ones a mix rewrites
        if ($urandom_range(1) == 1) ix = IDX_W'($urandom_range(4));
      end else if (pick < 93) begin
        f = FUNC_MIX;
      end else begin
        f = FUNC_NONE;
      end
      send_item(f, ix, v, 1'b0, '0);
      sent++;
    end
  endtask

  // receiver side: random stall, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: unexpected read transfer, value %08h", read_value_o);
      end else begin
        want_word = pending_reads.pop_front();
        if (read_value_o !== want_word) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb: read_value mismatch, expected %08h got %08h",
                     want_word, read_value_o);
        end
      end
    end
  end

  // ------------------------------------------------------------- sequence

  initial begin
    foreach (mix_state[n]) mix_state[n] = '0;
    send_idle_pct = 35;
    recv_idle_pct <= 87;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < DIR_ROWS; n++)
      send_item(dir_rows[n].func, dir_rows[n].idx, dir_rows[n].value,
                dir_rows[n].known, dir_rows[n].known_word);
    random_traffic(PHASE_ITEMS);
    wait_results();

    send_idle_pct = 87;
    recv_idle_pct <= 35;
    random_traffic(PHASE_ITEMS);
    wait_results();

    // long receiver hold-off while reads keep coming, so the input backs up
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= hold_req + 1;
    for (int n = 0; n < HOLD_READS; n++)
      send_item(FUNC_READ, IDX_W'($urandom_range(63)), $urandom, 1'b0, '0);
    random_traffic(TOTAL_RANDOM - 2 * PHASE_ITEMS - HOLD_READS);

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
sv/sam_pkg.sv
sv/sam_front.sv
sv/sam_back.sv
sv/state_array_arx_mixer.sv
sim/state_array_arx_mixer_tb.sv
